>>> design/fhi_pkg.sv
// Package for the fingerprint hash index: widths, status codes, constants.
// No dependencies.
`default_nettype none
package fhi_pkg;
	localparam int SLOT_COUNT_DEF   = 1024;
	localparam int HANDLE_COUNT_DEF = 1024;
	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 11;
	localparam int FP_W     = 32;
	localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		status_t             status;
	} result_t;

	typedef struct packed {
		logic          req_load;   // capture request
		logic [2:0]    hash_step;  // step code: 1 mul1, 2 xs30, 3 mul2, 4 xs27, 5 xs31
		logic          mul_lo;     // partial product selection
		logic          probe_init; // set probe position and count
		logic          slot_rd;    // issue slot read
		logic          key_rd;     // issue key read
		logic          key_wr;     // write key store
		logic          slot_wr;    // claim slot
		logic          probe_next; // advance position
	} dp_cmd_t;

	typedef struct packed {
		logic bad_handle;
		logic zero_key;
		logic is_lookup;
		logic slot_empty;
		logic fp_match;
		logic key_match;
		logic probes_done;
		logic clear_done;
	} dp_status_t;
endpackage
`default_nettype wire

>>> design/fhi_if.sv
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
`default_nettype none
interface fhi_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/fhi_datapath.sv
// Datapath: hash unit, slot table, key store, match logic.
// Depends on fhi_pkg.
`default_nettype none
module fhi_datapath #(
	parameter int SLOT_COUNT   = fhi_pkg::SLOT_COUNT_DEF,
	parameter int HANDLE_COUNT = fhi_pkg::HANDLE_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_op,
	input  wire logic [fhi_pkg::KEY_W-1:0]    in_key,
	input  wire logic [fhi_pkg::HANDLE_W-1:0] in_handle,
	input  wire fhi_pkg::dp_cmd_t             cmd,
	input  wire logic                         clr_en,
	output fhi_pkg::dp_status_t               stat,
	output logic [fhi_pkg::HANDLE_W-1:0]      slot_handle,
	output logic [fhi_pkg::HANDLE_W-1:0]      req_handle
);
	import fhi_pkg::*;
	localparam int SW = $clog2(SLOT_COUNT);
	localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
	localparam int CW = $clog2(SLOT_COUNT + 1);

	logic [KEY_W-1:0]    key_q, hash_q, acc_q;
	logic                op_q;
	logic [HANDLE_W-1:0] nh_q;
	logic [FP_W-1:0]     fp_q;
	logic [SW-1:0]       pos_q, clr_q;
	logic [CW-1:0]       cnt_q;
	logic                clr_done_q;

	logic [FP_W-1:0]     fp_mem [SLOT_COUNT];
	logic [HANDLE_W-1:0] hd_mem [SLOT_COUNT];
	logic [KEY_W-1:0]    key_mem [HANDLE_COUNT];
	logic [FP_W-1:0]     fp_rd_q;
	logic [HANDLE_W-1:0] hd_rd_q;
	logic [KEY_W-1:0]    key_rd_q;

	logic [KEY_W-1:0] mul_c, pp;
	logic [31:0]      hi_a, lo_a;
	logic [FP_W-1:0]  fp_raw;
	logic [HANDLE_W-1:0] hd_m1;
	logic [SW-1:0]    pos_home;

	// 64x64 low product as three 32x32 partials: low partial first, then the cross terms
	assign mul_c = (cmd.hash_step == 3'd1) ? MIX_C1 : MIX_C2;
	assign lo_a  = hash_q[31:0];
	assign hi_a  = hash_q[63:32];
	always_comb begin
		if (cmd.mul_lo) begin
			pp = 64'(lo_a) * 64'(mul_c[31:0]);
		end else begin
			pp = {32'(hi_a * mul_c[31:0] + lo_a * mul_c[63:32]), 32'd0};
		end
	end

	// home slot: low hash bits, SLOT_COUNT a power of two
	assign fp_raw   = hash_q[31:0] ^ hash_q[63:32];
	assign pos_home = hash_q[SW-1:0];
	assign hd_m1    = hd_rd_q - HANDLE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (clr_en && !clr_done_q) begin
			clr_q <= clr_q + SW'(1);
			if (clr_q == SW'(SLOT_COUNT - 1)) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q   <= in_op;
			key_q  <= in_key;
			nh_q   <= in_handle;
			hash_q <= in_key;
		end
		unique case (cmd.hash_step)
			3'd0: ;
			3'd1, 3'd3: begin
				if (cmd.mul_lo) begin
					acc_q <= pp;
				end else begin
					hash_q <= acc_q + pp;
				end
			end
			3'd2: hash_q <= hash_q ^ (hash_q >> 30);
			3'd4: hash_q <= hash_q ^ (hash_q >> 27);
			3'd5: hash_q <= hash_q ^ (hash_q >> 31);
			default: ;
		endcase
		if (cmd.probe_init) begin
			pos_q <= pos_home;
			cnt_q <= '0;
			fp_q  <= (fp_raw == '0) ? FP_W'(1) : fp_raw;
		end else if (cmd.probe_next) begin
			pos_q <= (pos_q == SW'(SLOT_COUNT - 1)) ? '0 : pos_q + SW'(1);
			cnt_q <= cnt_q + CW'(1);
		end
		if (clr_en && !clr_done_q) begin
			fp_mem[clr_q] <= '0;
			hd_mem[clr_q] <= '0;
		end else if (cmd.slot_wr) begin
			fp_mem[pos_q] <= fp_q;
			hd_mem[pos_q] <= nh_q;
		end
		if (cmd.slot_rd) begin
			fp_rd_q <= fp_mem[pos_q];
			hd_rd_q <= hd_mem[pos_q];
		end
		if (cmd.key_wr) begin
			key_mem[HW'(nh_q - HANDLE_W'(1))] <= key_q;
		end
		if (cmd.key_rd) begin
			key_rd_q <= key_mem[HW'(hd_m1)];
		end
	end

	always_comb begin
		stat.bad_handle  = (nh_q == '0) || (32'(nh_q) > HANDLE_COUNT);
		stat.zero_key    = (key_q == '0);
		stat.is_lookup   = op_q;
		stat.slot_empty  = (hd_rd_q == '0);
		stat.fp_match    = (fp_rd_q == fp_q) && (32'(hd_rd_q) <= HANDLE_COUNT);
		stat.key_match   = (key_rd_q == key_q);
		stat.probes_done = (cnt_q == CW'(SLOT_COUNT));
		stat.clear_done  = clr_done_q;
	end
	assign slot_handle = hd_rd_q;
	assign req_handle  = nh_q;
endmodule
`default_nettype wire

>>> design/fhi_ctrl.sv
// Controller: sequences hashing, probing and the result register.
// Depends on fhi_pkg.
`default_nettype none
module fhi_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output fhi_pkg::result_t                  out_res,
	output fhi_pkg::dp_cmd_t                  cmd,
	output logic                              clr_en,
	input  wire fhi_pkg::dp_status_t          stat,
	input  wire logic [fhi_pkg::HANDLE_W-1:0] slot_handle,
	input  wire logic [fhi_pkg::HANDLE_W-1:0] req_handle
);
	import fhi_pkg::*;
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_X30, S_M1L, S_M1H, S_X27, S_M2L, S_M2H, S_X31,
		S_INIT, S_RD, S_CHK, S_KEY, S_DONE
	} state_t;
	state_t state_q, nxt;
	result_t res_n;
	logic fin;

	assign clr_en   = (state_q == S_CLEAR);
	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		nxt = state_q;
		fin = 1'b0;
		res_n = '{handle_out: '0, status: ST_NOT_FOUND};
		unique case (state_q)
			S_CLEAR: if (stat.clear_done) nxt = S_IDLE;
			S_IDLE: if (in_valid && in_ready) begin
				cmd.req_load = 1'b1;
				nxt = S_X30;
			end
			S_X30: begin cmd.hash_step = 3'd2; nxt = S_M1L; end
			S_M1L: begin cmd.hash_step = 3'd1; cmd.mul_lo = 1'b1; nxt = S_M1H; end
			S_M1H: begin cmd.hash_step = 3'd1; nxt = S_X27; end
			S_X27: begin cmd.hash_step = 3'd4; nxt = S_M2L; end
			S_M2L: begin cmd.hash_step = 3'd3; cmd.mul_lo = 1'b1; nxt = S_M2H; end
			S_M2H: begin cmd.hash_step = 3'd3; nxt = S_X31; end
			S_X31: begin cmd.hash_step = 3'd5; nxt = S_INIT; end
			S_INIT: begin
				cmd.probe_init = 1'b1;
				if (stat.is_lookup ? stat.zero_key : stat.bad_handle) begin
					fin = 1'b1;
				end else begin
					cmd.key_wr = !stat.is_lookup;
					nxt = S_RD;
				end
			end
			S_RD: begin
				if (stat.probes_done) begin
					fin = 1'b1;
					if (!stat.is_lookup) res_n.status = ST_FULL;
				end else begin
					cmd.slot_rd = 1'b1;
					nxt = S_CHK;
				end
			end
			S_CHK: begin
				if (stat.slot_empty) begin
					fin = 1'b1;
					if (!stat.is_lookup) begin
						cmd.slot_wr = 1'b1;
						res_n = '{handle_out: req_handle, status: ST_OK};
					end
				end else if (stat.fp_match) begin
					cmd.key_rd = 1'b1;
					nxt = S_KEY;
				end else begin
					cmd.probe_next = 1'b1;
					nxt = S_RD;
				end
			end
			S_KEY: begin
				if (stat.key_match) begin
					fin = 1'b1;
					res_n = '{handle_out: slot_handle,
						status: stat.is_lookup ? ST_OK : ST_PRESENT};
				end else begin
					cmd.probe_next = 1'b1;
					nxt = S_RD;
				end
			end
			S_DONE: if (out_ready) nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
		if (fin) nxt = S_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			out_valid <= 1'b0;
			out_res   <= '0;
		end else begin
			state_q <= nxt;
			if (fin) begin
				out_valid <= 1'b1;
				out_res   <= res_n;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_valid) else $error("result overwritten");
	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |-> !in_ready) else $error("accept during clear");
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> out_valid) else $error("done without result");
`endif
endmodule
`default_nettype wire

>>> design/fingerprint_hash_index.sv
// Fingerprint hash index top: splitmix64 hash, linear probing over slot table.
// Sequence: hash and set up, then per probe a slot read and check, plus a key read on fingerprint match.
// Throughput: one transaction at a time; next accepted the cycle after result is taken.
// Reset: clearing pass over every slot of the slot table, no accept meanwhile.
// SLOT_COUNT must be a power of two. Depends on fhi_pkg, fhi_if, fhi_ctrl, fhi_datapath.
`default_nettype none
module fingerprint_hash_index #(
	parameter int SLOT_COUNT   = fhi_pkg::SLOT_COUNT_DEF,
	parameter int HANDLE_COUNT = fhi_pkg::HANDLE_COUNT_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fhi_if.sink      req,
	fhi_if.source    rsp
);
	import fhi_pkg::*;
	dp_cmd_t    cmd;
	dp_status_t stat;
	logic       clr_en;
	logic [HANDLE_W-1:0] slot_handle, req_handle;
	result_t    res;

	fhi_datapath #(.SLOT_COUNT(SLOT_COUNT), .HANDLE_COUNT(HANDLE_COUNT)) u_dp (
		.clk, .arst_n,
		.in_op(req.data[KEY_W+HANDLE_W]),
		.in_key(req.data[KEY_W+HANDLE_W-1:HANDLE_W]),
		.in_handle(req.data[HANDLE_W-1:0]),
		.cmd, .clr_en, .stat, .slot_handle, .req_handle
	);
	fhi_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_res(res),
		.cmd, .clr_en, .stat, .slot_handle, .req_handle
	);
	assign rsp.data = res;
endmodule
`default_nettype wire
